[hw/rtl/snas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snas_pkg
// Shared types, widths and fixed-point constants of the spiking neuron array
// update pipeline (Izhikevich neurons, signed Q16.16 arithmetic).
// ----------------------------------------------------------------------------
package snas_pkg;

  // array geometry
  localparam int NEURONS = 1024;
  localparam int SLOT_W  = $clog2(NEURONS);
  localparam int IDX_W   = 10;

  // field widths
  localparam int VW     = 32;
  localparam int TW     = 16;
  localparam int AW     = 17;
  localparam int DW     = 22;
  localparam int NEXC_W = 11;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_EXC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_EXC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_INH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_EXC   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_INH   = 3'd4;

  // register reset values
  localparam logic [NEXC_W-1:0] NUM_EXC_RST = 11'd800;
  localparam logic [AW-1:0]     A_EXC_RST   = 17'd1311;
  localparam logic [AW-1:0]     A_INH_RST   = 17'd6554;
  localparam logic [DW-1:0]     D_EXC_RST   = 22'd524288;
  localparam logic [DW-1:0]     D_INH_RST   = 22'd131072;

  // model constants, Q16.16 unless noted
  localparam logic signed [VW-1:0] V_FIRE  = 32'sd1966080;
  localparam logic signed [VW-1:0] V_RESET = -32'sd4259840;
  localparam logic signed [VW-1:0] K_FIVE  = 32'sd327680;
  localparam logic signed [VW-1:0] K_140   = 32'sd9175040;
  localparam logic signed [12:0]   K_004   = 13'sd2621;
  localparam logic signed [14:0]   K_02    = 15'sd13107;
  // trace constants, Q0.16
  localparam logic [TW-1:0] K_DECAY = 16'd62259;
  localparam logic [TW-1:0] K_LTP   = 16'd6554;
  localparam logic [TW-1:0] K_LTD   = 16'd7864;

  // intermediate widths
  localparam int P1_W    = VW + 13;          // 0.04 * v
  localparam int SLOPE_W = 30;               // (0.04 * v) + 5
  localparam int P2_W    = SLOPE_W + VW;     // slope * v
  localparam int SAT_W   = 48;               // wide sums before saturation
  localparam int Q_W     = VW + 15;          // 0.2 * v
  localparam int QS_W    = Q_W - 16;         // 0.2 * v after shift
  localparam int DIFF_W  = VW + 1;           // 0.2 * v - u
  localparam int PROD_W  = DIFF_W + AW + 1;  // a * diff

  // tagged pipeline stages of each unit (the result register is not counted)
  localparam int FRONT_STAGES = 2;
  localparam int HS_STAGES    = 3;
  localparam int REC_STAGES   = 3;
  localparam int TAG_N        = FRONT_STAGES + 2 * HS_STAGES + REC_STAGES;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-64'sd2147483648);

  typedef struct packed {
    logic [NEXC_W-1:0] num_exc;
    logic [AW-1:0]     a_exc;
    logic [AW-1:0]     a_inh;
    logic [DW-1:0]     d_exc;
    logic [DW-1:0]     d_inh;
  } cfg_t;

  // per-neuron stored state
  typedef struct packed {
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] u;
    logic [TW-1:0]        ltp;
    logic [TW-1:0]        ltd;
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    state_t            data;
  } wr_t;

  // request travelling down the pipeline
  typedef struct packed {
    logic                 load;
    logic [IDX_W-1:0]     nidx;
    logic                 fired;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] u;
    logic signed [VW-1:0] cur;
    logic [AW-1:0]        a;
    logic [TW-1:0]        ltp;
    logic [TW-1:0]        ltd;
  } item_t;

  // occupancy of one pipeline stage, for the read-after-write check
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] nidx;
  } tag_t;

  // clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [VW-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [VW-1:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/spiking_neuron_array_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiking_neuron_array_step
// Izhikevich neuron array update: one load or one step per request, state
// kept per neuron in an on-chip memory, 12-deep pipeline.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  in_       in_valid / in_ready    operation, neuron_index, input_current,
//                                   initial_voltage
//  out_      out_valid / out_ready  neuron_number, fired, membrane_voltage,
//                                   potentiation_trace, depression_trace
//  cfg_      cfg_wr_en              cfg_index, cfg_wdata
//
// One request per cycle enters while in_ready is high; its result is
// registered through the front, half-step and recovery stages. A step on a
// neuron whose earlier request has not yet written back waits for that
// write, so the memory read-modify-write loop paces a run on one neuron.
// rst_n clears the pipeline valids and loads the register defaults; the
// state memory is not cleared. A waiting result with out_ready low freezes
// the whole pipeline.
//
module spiking_neuron_array_step
  import snas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_operation,
  input  logic [IDX_W-1:0]       in_neuron_index,
  input  logic signed [VW-1:0]   in_input_current,
  input  logic signed [VW-1:0]   in_initial_voltage,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       out_neuron_number,
  output logic                   out_fired,
  output logic signed [VW-1:0]   out_membrane_voltage,
  output logic [TW-1:0]          out_potentiation_trace,
  output logic [TW-1:0]          out_depression_trace,

  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t   cfg_r;
  logic   adv;
  logic   hazard;
  logic   take;
  state_t mem_q;
  wr_t    wr;

  logic  fr_vld;
  item_t fr_item;
  logic  hs0_vld;
  item_t hs0_item;
  logic  hs1_vld;
  item_t hs1_item;
  logic  rc_vld;
  item_t rc_item;

  tag_t [FRONT_STAGES-1:0] fr_tags;
  tag_t [HS_STAGES-1:0]    hs0_tags;
  tag_t [HS_STAGES-1:0]    hs1_tags;
  tag_t [REC_STAGES-1:0]   rc_tags;
  tag_t [TAG_N-1:0]        all_tags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_exc <= NUM_EXC_RST;
      cfg_r.a_exc   <= A_EXC_RST;
      cfg_r.a_inh   <= A_INH_RST;
      cfg_r.d_exc   <= D_EXC_RST;
      cfg_r.d_inh   <= D_INH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_EXC: cfg_r.num_exc <= cfg_wdata[NEXC_W-1:0];
        REG_A_EXC:   cfg_r.a_exc   <= cfg_wdata[AW-1:0];
        REG_A_INH:   cfg_r.a_inh   <= cfg_wdata[AW-1:0];
        REG_D_EXC:   cfg_r.d_exc   <= cfg_wdata[DW-1:0];
        REG_D_INH:   cfg_r.d_inh   <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the result register is free or being taken
  assign adv = !out_valid || out_ready;

  // a step must not read a neuron that an in-flight request still writes
  assign all_tags = {rc_tags, hs1_tags, hs0_tags, fr_tags};

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < TAG_N; i++) begin
      if (all_tags[i].vld &&
          (SLOT_W'(all_tags[i].nidx) == SLOT_W'(in_neuron_index))) begin
        hazard = 1'b1;
      end
    end
    hazard = hazard && !in_operation;
  end

  assign in_ready = adv && !hazard;
  assign take     = in_valid && in_ready;

  // state memory
  snas_state_mem u_mem (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (SLOT_W'(in_neuron_index)),
    .rd_data (mem_q),
    .wr      (wr)
  );

  // spike check and trace decay
  snas_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .take     (take),
    .in_load  (in_operation),
    .in_nidx  (in_neuron_index),
    .in_cur   (in_input_current),
    .in_vinit (in_initial_voltage),
    .cfg      (cfg_r),
    .mem_q    (mem_q),
    .out_vld  (fr_vld),
    .out_item (fr_item),
    .tags     (fr_tags)
  );

  // two voltage half-steps
  snas_half_step u_hs0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .in_item  (fr_item),
    .out_vld  (hs0_vld),
    .out_item (hs0_item),
    .tags     (hs0_tags)
  );

  snas_half_step u_hs1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (hs0_vld),
    .in_item  (hs0_item),
    .out_vld  (hs1_vld),
    .out_item (hs1_item),
    .tags     (hs1_tags)
  );

  // recovery update, write-back and result register
  snas_recovery u_rec (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (hs1_vld),
    .in_item  (hs1_item),
    .out_vld  (rc_vld),
    .out_item (rc_item),
    .wr       (wr),
    .tags     (rc_tags)
  );

  // result ports
  assign out_valid              = rc_vld;
  assign out_neuron_number      = rc_item.nidx;
  assign out_fired              = rc_item.fired;
  assign out_membrane_voltage   = rc_item.v;
  assign out_potentiation_trace = rc_item.ltp;
  assign out_depression_trace   = rc_item.ltd;

endmodule

[hw/rtl/snas_state_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snas_state_mem
// Per-neuron state memory: v, u and both traces in one word, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module snas_state_mem
  import snas_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output state_t            rd_data,
  input  wr_t               wr
);

  state_t store_mem [NEURONS];
  state_t rd_data_r;

  // write back from the end of the pipeline
  always_ff @(posedge clk) begin
    if (wr.en) begin
      store_mem[wr.addr] <= wr.data;
    end
  end

  // registered read, held while no new request enters
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/snas_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snas_front
// Entry stages: captures the request beside the memory read, selects the
// excitatory or inhibitory parameters, applies the spike reset and decays
// the traces.
// ----------------------------------------------------------------------------
module snas_front
  import snas_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              take,
  input  logic                              in_load,
  input  logic [IDX_W-1:0]                  in_nidx,
  input  logic signed [VW-1:0]              in_cur,
  input  logic signed [VW-1:0]              in_vinit,
  input  cfg_t                              cfg,
  input  state_t                            mem_q,
  output logic                              out_vld,
  output item_t                             out_item,
  output tag_t [FRONT_STAGES-1:0]           tags
);

  logic                 f1_vld_r;
  logic                 f1_load_r;
  logic [IDX_W-1:0]     f1_nidx_r;
  logic signed [VW-1:0] f1_cur_r;
  logic signed [VW-1:0] f1_vinit_r;

  logic                 f2_vld_r;
  item_t                f2_item_r;
  item_t                f2_item_nxt;

  logic                 exc;
  logic                 fire;
  logic [DW-1:0]        d_sel;
  logic signed [SAT_W-1:0] u_sum;
  logic [TW-1:0]        ltp_sel;
  logic [TW-1:0]        ltd_sel;
  logic [2*TW-1:0]      ltp_prod;
  logic [2*TW-1:0]      ltd_prod;

  // stage 1: request captured as the memory read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      f1_load_r  <= in_load;
      f1_nidx_r  <= in_nidx;
      f1_cur_r   <= in_cur;
      f1_vinit_r <= in_vinit;
    end
  end

  // neuron class picks a and d
  assign exc   = {1'b0, f1_nidx_r} < cfg.num_exc;
  assign d_sel = exc ? cfg.d_exc : cfg.d_inh;

  // spike check on the stored voltage
  assign fire  = !f1_load_r && ($signed(mem_q.v) >= V_FIRE);
  assign u_sum = SAT_W'($signed(mem_q.u)) + SAT_W'($signed({1'b0, d_sel}));

  // trace reset on spike, then decay by 0.95
  assign ltp_sel  = fire ? K_LTP : mem_q.ltp;
  assign ltd_sel  = fire ? K_LTD : mem_q.ltd;
  assign ltp_prod = (2*TW)'(ltp_sel) * (2*TW)'(K_DECAY);
  assign ltd_prod = (2*TW)'(ltd_sel) * (2*TW)'(K_DECAY);

  always_comb begin
    f2_item_nxt.load  = f1_load_r;
    f2_item_nxt.nidx  = f1_nidx_r;
    f2_item_nxt.fired = fire;
    f2_item_nxt.cur   = f1_cur_r;
    f2_item_nxt.a     = exc ? cfg.a_exc : cfg.a_inh;
    if (f1_load_r) begin
      f2_item_nxt.v   = f1_vinit_r;
      f2_item_nxt.u   = mem_q.u;
      f2_item_nxt.ltp = '0;
      f2_item_nxt.ltd = '0;
    end else begin
      f2_item_nxt.v   = fire ? V_RESET : mem_q.v;
      f2_item_nxt.u   = fire ? sat32(u_sum) : mem_q.u;
      f2_item_nxt.ltp = ltp_prod[2*TW-1:TW];
      f2_item_nxt.ltd = ltd_prod[2*TW-1:TW];
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_item_r <= f2_item_nxt;
    end
  end

  assign out_vld  = f2_vld_r;
  assign out_item = f2_item_r;

  assign tags[0] = '{vld: f1_vld_r, nidx: f1_nidx_r};
  assign tags[1] = '{vld: f2_vld_r, nidx: f2_item_r.nidx};

endmodule

[hw/rtl/snas_half_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snas_half_step
// One Euler half-step of the membrane voltage in three stages:
// 0.04*v, then (0.04*v + 5)*v, then v += 0.5*(... + 140 - u + I) with
// saturation. Load requests pass v through unchanged.
// ----------------------------------------------------------------------------
module snas_half_step
  import snas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  item_t                  in_item,
  output logic                   out_vld,
  output item_t                  out_item,
  output tag_t [HS_STAGES-1:0]   tags
);

  logic h1_vld_r;
  logic h2_vld_r;
  logic h3_vld_r;
  item_t h1_item_r;
  item_t h2_item_r;
  item_t h3_item_r;
  item_t h3_item_nxt;

  logic signed [P1_W-1:0]    p1_nxt;
  logic signed [P1_W-1:0]    h1_p1_r;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [P2_W-1:0]    p2_nxt;
  logic signed [P2_W-1:0]    h2_p2_r;
  logic signed [SAT_W-1:0]   deriv;
  logic signed [SAT_W-1:0]   v_sum;

  // stage 1: 0.04 * v
  assign p1_nxt = $signed(in_item.v) * K_004;

  // stage 2: slope * v
  assign slope  = SLOPE_W'($signed(h1_p1_r[P1_W-1:16])) + SLOPE_W'(K_FIVE);
  assign p2_nxt = slope * $signed(h1_item_r.v);

  // stage 3: derivative, halved toward minus infinity, then saturate
  assign deriv = SAT_W'($signed(h2_p2_r[P2_W-1:16])) + SAT_W'(K_140)
               - SAT_W'($signed(h2_item_r.u)) + SAT_W'($signed(h2_item_r.cur));
  assign v_sum = SAT_W'($signed(h2_item_r.v)) + (deriv >>> 1);

  always_comb begin
    h3_item_nxt = h2_item_r;
    if (!h2_item_r.load) begin
      h3_item_nxt.v = sat32(v_sum);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
      h2_vld_r <= 1'b0;
      h3_vld_r <= 1'b0;
    end else if (adv) begin
      h1_vld_r <= in_vld;
      h2_vld_r <= h1_vld_r;
      h3_vld_r <= h2_vld_r;
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (adv) begin
      h1_item_r <= in_item;
      h1_p1_r   <= p1_nxt;
      h2_item_r <= h1_item_r;
      h2_p2_r   <= p2_nxt;
      h3_item_r <= h3_item_nxt;
    end
  end

  assign out_vld  = h3_vld_r;
  assign out_item = h3_item_r;

  assign tags[0] = '{vld: h1_vld_r, nidx: h1_item_r.nidx};
  assign tags[1] = '{vld: h2_vld_r, nidx: h2_item_r.nidx};
  assign tags[2] = '{vld: h3_vld_r, nidx: h3_item_r.nidx};

endmodule

[hw/rtl/snas_recovery.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snas_recovery
// Recovery update u += a*(0.2*v - u) in three stages, state write-back and
// the result register. A load takes u = 0.2*v from the same multiplier.
// ----------------------------------------------------------------------------
module snas_recovery
  import snas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  item_t                  in_item,
  output logic                   out_vld,
  output item_t                  out_item,
  output wr_t                    wr,
  output tag_t [REC_STAGES-1:0]  tags
);

  logic r1_vld_r;
  logic r2_vld_r;
  logic r3_vld_r;
  logic r4_vld_r;
  item_t r1_item_r;
  item_t r2_item_r;
  item_t r3_item_r;
  item_t r4_item_r;
  item_t r4_item_nxt;

  logic signed [Q_W-1:0]    q_nxt;
  logic signed [Q_W-1:0]    r1_q_r;
  logic signed [QS_W-1:0]   q16;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [DIFF_W-1:0] r2_diff_r;
  logic signed [QS_W-1:0]   r2_q16_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] r3_prod_r;
  logic signed [QS_W-1:0]   r3_q16_r;
  logic signed [SAT_W-1:0]  u_sum;

  // stage 1: 0.2 * v
  assign q_nxt = $signed(in_item.v) * K_02;

  // stage 2: 0.2 * v - u
  assign q16      = $signed(r1_q_r[Q_W-1:16]);
  assign diff_nxt = DIFF_W'(q16) - DIFF_W'($signed(r1_item_r.u));

  // stage 3: a * diff
  assign prod_nxt = r2_diff_r * $signed({1'b0, r2_item_r.a});

  // final u, load takes the scaled voltage directly
  assign u_sum = SAT_W'($signed(r3_prod_r[PROD_W-1:16])) + SAT_W'($signed(r3_item_r.u));

  always_comb begin
    r4_item_nxt = r3_item_r;
    if (r3_item_r.load) begin
      r4_item_nxt.u = VW'(r3_q16_r);
    end else begin
      r4_item_nxt.u = sat32(u_sum);
    end
  end

  // write-back as the request moves into the result register
  assign wr.en        = adv && r3_vld_r;
  assign wr.addr      = SLOT_W'(r3_item_r.nidx);
  assign wr.data.v    = r4_item_nxt.v;
  assign wr.data.u    = r4_item_nxt.u;
  assign wr.data.ltp  = r4_item_nxt.ltp;
  assign wr.data.ltd  = r4_item_nxt.ltd;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
      r3_vld_r <= 1'b0;
      r4_vld_r <= 1'b0;
    end else if (adv) begin
      r1_vld_r <= in_vld;
      r2_vld_r <= r1_vld_r;
      r3_vld_r <= r2_vld_r;
      r4_vld_r <= r3_vld_r;
    end
  end

  // data chain
  always_ff @(posedge clk) begin
    if (adv) begin
      r1_item_r <= in_item;
      r1_q_r    <= q_nxt;
      r2_item_r <= r1_item_r;
      r2_diff_r <= diff_nxt;
      r2_q16_r  <= q16;
      r3_item_r <= r2_item_r;
      r3_prod_r <= prod_nxt;
      r3_q16_r  <= r2_q16_r;
      r4_item_r <= r4_item_nxt;
    end
  end

  assign out_vld  = r4_vld_r;
  assign out_item = r4_item_r;

  assign tags[0] = '{vld: r1_vld_r, nidx: r1_item_r.nidx};
  assign tags[1] = '{vld: r2_vld_r, nidx: r2_item_r.nidx};
  assign tags[2] = '{vld: r3_vld_r, nidx: r3_item_r.nidx};

endmodule

[tb/sv/spiking_neuron_array_step_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiking_neuron_array_step_test
// Self-checking bench for the Izhikevich neuron array update. A built-in
// neuron predictor keeps its own copy of every neuron's voltage, recovery
// and trace state and of the five registers. It computes each result when a
// request is accepted. Directed corner requests come first. Random traffic
// follows on a few hot neurons plus wild values, with random sender gaps,
// receiver stalls and several register settings.
// ----------------------------------------------------------------------------
module spiking_neuron_array_step_test;
  import snas_pkg::*;

  localparam bit OP_STEP = 1'b0;
  localparam bit OP_LOAD = 1'b1;

  localparam int Q_ONE          = 65536;
  localparam int MAX_IDLE       = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REG_SPARE_LO   = REG_D_INH + 1;
  localparam int REG_SPARE_HI   = (1 << CFG_IDX_W) - 1;

  localparam longint V_MAX = 64'sd2147483647;
  localparam longint V_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]     nidx;
    logic                 fired;
    logic signed [VW-1:0] v;
    logic [TW-1:0]        ltp;
    logic [TW-1:0]        ltd;
  } neuron_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = 1'b0;
  logic [IDX_W-1:0]      in_neuron_index = '0;
  logic signed [VW-1:0]  in_input_current = '0;
  logic signed [VW-1:0]  in_initial_voltage = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [IDX_W-1:0]      out_neuron_number;
  logic                  out_fired;
  logic signed [VW-1:0]  out_membrane_voltage;
  logic [TW-1:0]         out_potentiation_trace;
  logic [TW-1:0]         out_depression_trace;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and the neuron state
  bit [NEXC_W-1:0] cfg_num_exc = NUM_EXC_RST;
  bit [AW-1:0]     cfg_a_exc   = A_EXC_RST;
  bit [AW-1:0]     cfg_a_inh   = A_INH_RST;
  bit [DW-1:0]     cfg_d_exc   = D_EXC_RST;
  bit [DW-1:0]     cfg_d_inh   = D_INH_RST;

  int          model_v [NEURONS];
  int          model_u [NEURONS];
  bit [TW-1:0] model_ltp [NEURONS];
  bit [TW-1:0] model_ltd [NEURONS];
  bit          loaded [NEURONS];

  neuron_result_t pending_results [$];

  bit          sender_gaps;
  bit          receiver_stalls;
  int unsigned mismatches;
  int unsigned loads_sent;
  int unsigned steps_sent;
  int unsigned spikes_seen;
  int unsigned cfg_settings;
  int unsigned quiet_cycles;

  spiking_neuron_array_step u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_operation           (in_operation),
    .in_neuron_index        (in_neuron_index),
    .in_input_current       (in_input_current),
    .in_initial_voltage     (in_initial_voltage),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_neuron_number      (out_neuron_number),
    .out_fired              (out_fired),
    .out_membrane_voltage   (out_membrane_voltage),
    .out_potentiation_trace (out_potentiation_trace),
    .out_depression_trace   (out_depression_trace),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // neuron predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(input longint x);
    if (x > V_MAX) return V_MAX;
    if (x < V_MIN) return V_MIN;
    return x;
  endfunction

  // one half-millisecond Euler step of the membrane voltage
  function automatic longint membrane_half_step(input longint v, u, cur);
    longint slope;
    longint deriv;
    slope = ((longint'(K_004) * v) >>> 16) + longint'(K_FIVE);
    deriv = ((slope * v) >>> 16) + longint'(K_140) - u + cur;
    return clamp32(v + (deriv >>> 1));
  endfunction

  function automatic neuron_result_t advance_neuron(input bit op,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic signed [VW-1:0] cur,
                                                    input logic signed [VW-1:0] vin);
    neuron_result_t r;
    longint         v;
    longint         u;
    longint         a;
    longint         d;
    bit [TW-1:0]    ltp;
    bit [TW-1:0]    ltd;
    int             slot;
    slot    = int'(idx) % NEURONS;
    r.fired = 1'b0;
    if (op == OP_LOAD) begin
      v   = vin;
      u   = (longint'(K_02) * v) >>> 16;
      ltp = '0;
      ltd = '0;
      loaded[slot] = 1'b1;
    end else begin
      if (idx < cfg_num_exc) begin
        a = cfg_a_exc;
        d = cfg_d_exc;
      end else begin
        a = cfg_a_inh;
        d = cfg_d_inh;
      end
      v   = model_v[slot];
      u   = model_u[slot];
      ltp = model_ltp[slot];
      ltd = model_ltd[slot];
      // spike on the stored voltage, before integrating
      if (v >= longint'(V_FIRE)) begin
        r.fired = 1'b1;
        v   = V_RESET;
        u   = clamp32(u + d);
        ltp = K_LTP;
        ltd = K_LTD;
      end
      v   = membrane_half_step(v, u, cur);
      v   = membrane_half_step(v, u, cur);
      u   = clamp32(u + ((a * (((longint'(K_02) * v) >>> 16) - u)) >>> 16));
      ltp = TW'((longint'(ltp) * longint'(K_DECAY)) >>> 16);
      ltd = TW'((longint'(ltd) * longint'(K_DECAY)) >>> 16);
    end
    model_v[slot]   = int'(v);
    model_u[slot]   = int'(u);
    model_ltp[slot] = ltp;
    model_ltd[slot] = ltd;
    r.nidx = idx;
    r.v    = VW'(v);
    r.ltp  = ltp;
    r.ltd  = ltd;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver and register writes
  // ---------------------------------------------------------------------------

  task automatic issue_request(input bit op, input logic [IDX_W-1:0] idx,
                               input logic signed [VW-1:0] cur,
                               input logic signed [VW-1:0] vin);
    int unsigned gap;
    gap = sender_gaps ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_neuron_index    <= idx;
    in_input_current   <= cur;
    in_initial_voltage <= vin;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_neuron(op, idx, cur, vin));
    if (op == OP_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // sender holds off until the pipeline has handed back everything
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // junk above the register width must be dropped by the block
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    case (idx)
      REG_NUM_EXC: begin
        data[NEXC_W-1:0] = NEXC_W'(value);
        cfg_num_exc      = NEXC_W'(value);
      end
      REG_A_EXC: begin
        data[AW-1:0] = AW'(value);
        cfg_a_exc    = AW'(value);
      end
      REG_A_INH: begin
        data[AW-1:0] = AW'(value);
        cfg_a_inh    = AW'(value);
      end
      REG_D_EXC: begin
        data      = DW'(value);
        cfg_d_exc = DW'(value);
      end
      REG_D_INH: begin
        data      = DW'(value);
        cfg_d_inh = DW'(value);
      end
      default: ;
    endcase
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // only called with the pipeline empty
  task automatic apply_config(input int unsigned nexc, a_exc, a_inh, d_exc, d_inh);
    write_register(REG_NUM_EXC, nexc);
    write_register(REG_A_EXC, a_exc);
    write_register(REG_A_INH, a_inh);
    write_register(REG_D_EXC, d_exc);
    write_register(REG_D_INH, d_inh);
    // an index past the register list must change nothing
    write_register(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
    cfg_wr_en <= 1'b0;
    cfg_settings++;
  endtask

  // mostly plausible membrane traffic on a few hot neurons, some wild values
  task automatic run_traffic(input int items, input bit s_gaps, input bit r_stalls,
                             input int unsigned noise_pct, input int pause_every);
    int unsigned          hot [8];
    int unsigned          idx;
    bit                   op;
    logic signed [VW-1:0] cur;
    logic signed [VW-1:0] vin;
    sender_gaps     = s_gaps;
    receiver_stalls = r_stalls;
    foreach (hot[k]) hot[k] = $urandom_range(0, NEURONS - 1);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 75) idx = hot[$urandom_range(0, 7)];
      else idx = $urandom_range(0, NEURONS - 1);
      // never step a neuron that was never loaded
      op = (!loaded[idx] || $urandom_range(0, 99) < 8) ? OP_LOAD : OP_STEP;
      if ($urandom_range(0, 99) < noise_pct) begin
        cur = $urandom;
        vin = $urandom;
      end else begin
        vin = $urandom_range(0, 100 * Q_ONE) - 70 * Q_ONE;
        cur = $urandom_range(0, 30 * Q_ONE) - 5 * Q_ONE;
      end
      issue_request(op, IDX_W'(idx), cur, vin);
      if (pause_every != 0 && n % pause_every == pause_every - 1) wait_for_results();
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    // neuron at zero, then the array's first and last index
    issue_request(OP_LOAD, IDX_W'(0), 32'sh7FFFFFFF, 0);
    issue_request(OP_STEP, IDX_W'(0), 0, 32'sh7FFFFFFF);
    // most positive voltage fires, huge current saturates high
    issue_request(OP_LOAD, IDX_W'(NEURONS - 1), 0, 32'sh7FFFFFFF);
    issue_request(OP_STEP, IDX_W'(NEURONS - 1), 32'sh7FFFFFFF, 0);
    issue_request(OP_STEP, IDX_W'(NEURONS - 1), 32'sh80000000, 0);
    // most negative voltage and current saturate low
    issue_request(OP_LOAD, IDX_W'(512), 0, 32'sh80000000);
    issue_request(OP_STEP, IDX_W'(512), 32'sh80000000, 0);
    // exactly at threshold fires, one below does not; excitatory edge
    issue_request(OP_LOAD, IDX_W'(NUM_EXC_RST - 1), 0, V_FIRE);
    issue_request(OP_LOAD, IDX_W'(NUM_EXC_RST), 0, V_FIRE);
    issue_request(OP_LOAD, IDX_W'(NUM_EXC_RST + 1), 0, V_FIRE - 1);
    issue_request(OP_STEP, IDX_W'(NUM_EXC_RST - 1), 10 * Q_ONE, 0);
    issue_request(OP_STEP, IDX_W'(NUM_EXC_RST), 10 * Q_ONE, 0);
    issue_request(OP_STEP, IDX_W'(NUM_EXC_RST + 1), 10 * Q_ONE, 0);
    // trace decay after a spike
    issue_request(OP_STEP, IDX_W'(NUM_EXC_RST - 1), 0, 0);
    issue_request(OP_STEP, IDX_W'(NUM_EXC_RST), 0, 0);
    // resting neuron stepped back to back
    issue_request(OP_LOAD, IDX_W'(341), 0, V_RESET);
    repeat (4) issue_request(OP_STEP, IDX_W'(341), 0, 0);
    // smallest negative voltage and current
    issue_request(OP_LOAD, IDX_W'(682), 0, -1);
    issue_request(OP_STEP, IDX_W'(682), -1, 0);
    wait_for_results();
  endtask

  task automatic test_default_network();
    run_traffic(250, 1'b1, 1'b1, 10, 0);
  endtask

  task automatic test_full_rate();
    run_traffic(150, 1'b0, 1'b0, 10, 0);
  endtask

  task automatic test_drained_pauses();
    run_traffic(150, 1'b0, 1'b1, 10, 40);
  endtask

  task automatic test_register_extremes();
    apply_config(0, 0, 0, 0, 0);
    run_traffic(100, 1'b1, 1'b0, 20, 0);
    apply_config((1 << NEXC_W) - 1, (1 << AW) - 1, (1 << AW) - 1,
                 (1 << DW) - 1, (1 << DW) - 1);
    run_traffic(100, 1'b0, 1'b1, 20, 0);
    apply_config(NEURONS, Q_ONE, Q_ONE, 32 * Q_ONE, 32 * Q_ONE);
    run_traffic(100, 1'b1, 1'b1, 20, 0);
    apply_config($urandom_range(0, NEURONS), $urandom_range(0, Q_ONE),
                 $urandom_range(0, Q_ONE), $urandom_range(0, 32 * Q_ONE),
                 $urandom_range(0, 32 * Q_ONE));
    run_traffic(100, 1'b1, 1'b1, 20, 0);
    apply_config(NUM_EXC_RST, A_EXC_RST, A_INH_RST, D_EXC_RST, D_INH_RST);
  endtask

  task automatic test_wild_values();
    run_traffic(150, 1'b1, 1'b1, 100, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_default_network();
    test_full_rate();
    test_drained_pauses();
    test_register_extremes();
    test_wild_values();
    wait_for_results();
    repeat (TAG_N + 4) @(posedge clk);
    $display("covered %0d loads and %0d steps (%0d spikes) over %0d register settings",
             loads_sent, steps_sent, spikes_seen, cfg_settings + 1);
    $display("with sender gaps, receiver stalls, full-rate runs and drained pauses");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [VW-1:0] want,
                               input logic [VW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_checker
    neuron_result_t want;
    int unsigned    stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result for neuron %0d with no request waiting", out_neuron_number);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (want.fired) spikes_seen++;
        compare_field("neuron_number", VW'(want.nidx), VW'(out_neuron_number));
        compare_field("fired", VW'(want.fired), VW'(out_fired));
        compare_field("membrane_voltage", want.v, out_membrane_voltage);
        compare_field("potentiation_trace", VW'(want.ltp), VW'(out_potentiation_trace));
        compare_field("depression_trace", VW'(want.ltd), VW'(out_depression_trace));
      end
    end
  end

  // watchdog on cycles where neither channel moves a request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[files.f]
hw/rtl/snas_pkg.sv
hw/rtl/snas_state_mem.sv
hw/rtl/snas_front.sv
hw/rtl/snas_half_step.sv
hw/rtl/snas_recovery.sv
hw/rtl/spiking_neuron_array_step.sv
tb/sv/spiking_neuron_array_step_test.sv
